@@ hw/rtl/median_filter_3x3_stream_core_macros.svh @@
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_FILTER_3X3_STREAM_CORE_MACROS_SVH
`define MEDIAN_FILTER_3X3_STREAM_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define MF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mf3 assertion failed");

// Next-cycle implication, checked out of reset.
`define MF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mf3 assertion failed");

`else

`define MF3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MF3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/mf3_pkg.sv @@
// Shared types, constants and compare functions of the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

	localparam int MAX_SIZE_DEF = 1024;
	localparam int PIX_W        = 8;
	localparam int SIZE_W       = 11;
	localparam int POS_W        = 10;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_ADDR_W   = 3;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd10;

	// Register index, taken from address bit 2
	localparam logic REG_IMAGE_SIZE = 1'b0;

	typedef logic [PIX_W-1:0] pix_t;

	// One window column, sorted low to high
	typedef struct packed {
		pix_t hi;
		pix_t md;
		pix_t lo;
	} col_t;

	// Three sorted columns plus position of one interior result
	typedef struct packed {
		col_t             a;
		col_t             b;
		col_t             c;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} win_item_t;

	function automatic pix_t pmin(input pix_t x, input pix_t y);
		return (x < y) ? x : y;
	endfunction

	function automatic pix_t pmax(input pix_t x, input pix_t y);
		return (x < y) ? y : x;
	endfunction

	// Middle of three values
	function automatic pix_t med3(input pix_t x, input pix_t y, input pix_t z);
		return pmax(pmin(x, y), pmin(pmax(x, y), z));
	endfunction

	// Three compare-exchange steps
	function automatic col_t sort3(input pix_t x, input pix_t y, input pix_t z);
		col_t r;
		pix_t a;
		pix_t b;
		pix_t t;
		a = pmin(x, y);
		b = pmax(x, y);
		t = pmin(b, z);
		r.hi = pmax(b, z);
		r.lo = pmin(a, t);
		r.md = pmax(a, t);
		return r;
	endfunction

	// Bordered index of the last row/column for a written size
	function automatic int unsigned last_index(input logic [SIZE_W-1:0] size,
		input int unsigned max_size);
		int unsigned s;
		s = size;
		if (s < 1) s = 1;
		if (s > max_size) s = max_size;
		return s + 1;
	endfunction

endpackage

@@ hw/rtl/mf3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1026
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/mf3_cfg.sv @@
// APB register block: image_size and the derived last bordered index.
`timescale 1ns / 1ps

module mf3_cfg #(
	parameter int MAX_SIZE = mf3_pkg::MAX_SIZE_DEF,
	parameter int CW       = $clog2(MAX_SIZE + 2)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mf3_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [mf3_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output logic                             restart,
	output logic [CW-1:0]                    last_idx
);

	logic [mf3_pkg::SIZE_W-1:0] image_size_q;
	logic [CW-1:0]              last_idx_q;
	logic                       wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == mf3_pkg::REG_IMAGE_SIZE);

	// Frame restarts on every size write
	assign restart  = wr_hit;
	assign last_idx = last_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= mf3_pkg::SIZE_RESET;
			last_idx_q   <= CW'(mf3_pkg::last_index(mf3_pkg::SIZE_RESET, MAX_SIZE));
		end else if (wr_hit) begin
			image_size_q <= pwdata[mf3_pkg::SIZE_W-1:0];
			last_idx_q   <= CW'(mf3_pkg::last_index(pwdata[mf3_pkg::SIZE_W-1:0], MAX_SIZE));
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		if (paddr[2] == mf3_pkg::REG_IMAGE_SIZE) begin
			prdata = mf3_pkg::CFG_DATA_W'(image_size_q);
		end
	end

endmodule

@@ hw/rtl/mf3_median.sv @@
// Median of three sorted columns and the output register of the stream.
`timescale 1ns / 1ps

`include "median_filter_3x3_stream_core_macros.svh"

module mf3_median (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  mf3_pkg::win_item_t in_item,
	output logic               in_ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,  // median_value[7:0], out_row[17:8], out_col[27:18]
	output logic               m_tlast
);

	mf3_pkg::pix_t              lo_max;
	mf3_pkg::pix_t              md_med;
	mf3_pkg::pix_t              hi_min;
	mf3_pkg::pix_t              med;
	logic                       out_valid_q;
	mf3_pkg::pix_t              med_q;
	logic [mf3_pkg::POS_W-1:0]  row_q;
	logic [mf3_pkg::POS_W-1:0]  col_q;
	logic                       last_q;

	// Median of nine from sorted columns: med3(max of lows, med of mids, min of highs)
	always_comb begin
		lo_max = mf3_pkg::pmax(mf3_pkg::pmax(in_item.a.lo, in_item.b.lo), in_item.c.lo);
		md_med = mf3_pkg::med3(in_item.a.md, in_item.b.md, in_item.c.md);
		hi_min = mf3_pkg::pmin(mf3_pkg::pmin(in_item.a.hi, in_item.b.hi), in_item.c.hi);
		med    = mf3_pkg::med3(lo_max, md_med, hi_min);
	end

	assign in_ready = !out_valid_q || m_tready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			med_q  <= med;
			row_q  <= in_item.row;
			col_q  <= in_item.col;
			last_q <= in_item.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, col_q, row_q, med_q};
	assign m_tlast  = last_q;

	// The final result of a frame sits on the diagonal
	`MF3_ASSERT_IMP(a_last_diag, clk, arst_n, out_valid_q && last_q, row_q == col_q)
	// An item that is not taken stays in the output register
	`MF3_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid_q && !m_tready, out_valid_q)

endmodule

@@ hw/rtl/median_filter_3x3_stream_core.sv @@
// Top level of the streaming 3x3 median filter.
`timescale 1ns / 1ps

// Streaming 3x3 median filter. Pixels of a bordered (image_size+2)-square
// image enter on s_* one per clock in raster order, border included; each
// interior position yields one result on m_* (median, interior row and column,
// tlast on the final one of the frame), valid after its lower-right neighbor
// passes s1, s2 and the output register. Border pixels give no result.
// Throughput is one pixel per clock unless stalled, set by the single read and
// single write port of each of the two line-store RAMs (MAX_SIZE+2 entries,
// no clearing after reset). Writing image_size (byte address 0) restarts the
// frame; sizes of 0 act as 1 and sizes above MAX_SIZE act as MAX_SIZE.

`include "median_filter_3x3_stream_core_macros.svh"

module median_filter_3x3_stream_core #(
	parameter int MAX_SIZE = mf3_pkg::MAX_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mf3_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mf3_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [mf3_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // pixel[7:0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [31:0]                    m_tdata,  // median_value[7:0], out_row[17:8], out_col[27:18]
	output logic                           m_tlast
);

	localparam int DEPTH = MAX_SIZE + 2;
	localparam int CW    = $clog2(DEPTH);

	logic                      restart;
	logic [CW-1:0]             last_idx;
	logic [CW-1:0]             row_q;
	logic [CW-1:0]             col_q;
	logic                      accept;
	logic                      s1_adv;
	logic                      s2_adv;
	logic                      med_ready;

	logic                      valid_s1;
	mf3_pkg::pix_t             pixel_s1;
	logic [CW-1:0]             col_s1;
	logic                      emit_s1;
	logic                      last_s1;
	logic [mf3_pkg::POS_W-1:0] orow_s1;
	logic [mf3_pkg::POS_W-1:0] ocol_s1;

	mf3_pkg::pix_t             upper_rd;
	mf3_pkg::pix_t             middle_rd;
	logic                      line_we;
	mf3_pkg::col_t             new_col;
	mf3_pkg::col_t             win_a_q;
	mf3_pkg::col_t             win_b_q;

	logic                      valid_s2;
	mf3_pkg::win_item_t        item_s2;

	mf3_cfg #(
		.MAX_SIZE (MAX_SIZE),
		.CW       (CW)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.restart  (restart),
		.last_idx (last_idx)
	);

	// Stage advance chain; non-emitting items leave s1 without needing s2
	assign s2_adv   = !valid_s2 || med_ready;
	assign s1_adv   = !valid_s1 || !emit_s1 || s2_adv;
	assign s_tready = s1_adv;
	assign accept   = s_tvalid && s1_adv;

	// Bordered position of the next pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q == last_idx) begin
				col_q <= '0;
				row_q <= (row_q == last_idx) ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: pixel and position while line stores are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= s_tdata;
			col_s1   <= col_q;
			emit_s1  <= (row_q >= CW'(2)) && (col_q >= CW'(2));
			last_s1  <= (row_q == last_idx) && (col_q == last_idx);
			orow_s1  <= mf3_pkg::POS_W'(row_q - CW'(2));
			ocol_s1  <= mf3_pkg::POS_W'(col_q - CW'(2));
		end
	end

	// Line stores: rows r-2 and r-1 of the bordered image
	assign line_we = valid_s1 && s1_adv;

	mf3_ram #(
		.WIDTH (mf3_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_upper_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (col_s1),
		.wdata (middle_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (upper_rd)
	);

	mf3_ram #(
		.WIDTH (mf3_pkg::PIX_W),
		.DEPTH (DEPTH)
	) u_middle_line (
		.clk   (clk),
		.we    (line_we),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (middle_rd)
	);

	// Newest column, sorted
	assign new_col = mf3_pkg::sort3(upper_rd, middle_rd, pixel_s1);

	// Window keeps the two previous columns already sorted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_a_q <= '0;
			win_b_q <= '0;
		end else if (line_we) begin
			win_a_q <= win_b_q;
			win_b_q <= new_col;
		end
	end

	// Stage 2: three sorted columns of an interior position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_adv) begin
			valid_s2 <= valid_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && valid_s1 && emit_s1) begin
			item_s2.a    <= win_a_q;
			item_s2.b    <= win_b_q;
			item_s2.c    <= new_col;
			item_s2.row  <= orow_s1;
			item_s2.col  <= ocol_s1;
			item_s2.last <= last_s1;
		end
	end

	mf3_median u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_item  (item_s2),
		.in_ready (med_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Position counters stay inside the bordered frame
	`MF3_ASSERT_IMP(a_col_range, clk, arst_n, 1'b1, col_q <= last_idx)
	`MF3_ASSERT_IMP(a_row_range, clk, arst_n, 1'b1, row_q <= last_idx)
	// An accepted pixel always lands in stage 1
	`MF3_ASSERT_NXT(a_accept_s1, clk, arst_n, accept, valid_s1)
	// A stalled interior item in stage 1 is not dropped
	`MF3_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv, valid_s1 && emit_s1)

endmodule
